// File: design/hbf_pkg.sv
// Shared constants, types and register codes for the high-boost 3x3 filter.
// Used by every module and interface of the block but hbf_ram; depends on nothing else.
`default_nettype none

package hbf_pkg;

    // Row geometry and row-store sizing.
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int MIN_DIM   = 3;

    // Configuration register fields.
    localparam int CFG_W_W    = 11;
    localparam int CFG_H_W    = 16;
    localparam int CFG_GAIN_W = 12;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAIN   = 2'd2;

    localparam logic [CFG_W_W-1:0]    RST_WIDTH  = 11'd640;
    localparam logic [CFG_H_W-1:0]    RST_HEIGHT = 16'd480;
    localparam logic [CFG_GAIN_W-1:0] RST_GAIN   = 12'd2278;

    // Pixel layout.
    localparam int PIX_W    = 8;
    localparam int RGB_W    = 3 * PIX_W;
    localparam int WIN_ROWS = 3;

    // Filter arithmetic: gain is Q.8, the neighbor sum is scaled by 2^FRAC_W.
    localparam int FRAC_W      = 8;
    localparam int NSUM_W      = PIX_W + 3;
    localparam int PROD_W      = CFG_GAIN_W + PIX_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int X_W         = PROD_W - FRAC_W;
    localparam int RECIP_W     = 14;
    localparam int RECIP_SHIFT = 17;
    localparam int MQ_W        = X_W + RECIP_W;
    localparam int QUO_W       = MQ_W - RECIP_SHIFT;

    // Output queue.
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int LEVEL_W     = FIFO_PTR_W + 1;
    localparam int INFLIGHT_W  = 2;
    localparam int USED_W      = LEVEL_W + 1;

    localparam int EFF_W_W = (CFG_W_W > COL_W + 1) ? CFG_W_W : COL_W + 1;

    typedef logic [COL_W-1:0]      t_col;
    typedef logic [CFG_H_W-1:0]    t_row;
    typedef logic [EFF_W_W-1:0]    t_eff_w;
    typedef logic [PIX_W-1:0]      t_pix;
    typedef logic [RGB_W-1:0]      t_rgb;
    typedef logic [NSUM_W-1:0]     t_nsum;
    typedef logic [PROD_W-1:0]     t_prod;
    typedef logic [ACC_W-1:0]      t_acc;
    typedef logic [X_W-1:0]        t_x;
    typedef logic [MQ_W-1:0]       t_mq;
    typedef logic [QUO_W-1:0]      t_quo;
    typedef logic [FIFO_PTR_W-1:0] t_fifo_ptr;
    typedef logic [LEVEL_W-1:0]    t_level;
    typedef logic [INFLIGHT_W-1:0] t_inflight;
    typedef logic [USED_W-1:0]     t_used;

    localparam t_eff_w MIN_W_EXT = t_eff_w'(MIN_DIM);
    localparam t_eff_w MAX_W_EXT = t_eff_w'(MAX_WIDTH);
    localparam t_eff_w ONE_W_EXT = t_eff_w'(1);
    localparam t_row   MIN_H     = t_row'(MIN_DIM);

    // Reciprocal of nine, exact for quotient inputs below 2^RECIP_SHIFT / 4.
    localparam t_mq    RECIP_NINE = t_mq'(14564);
    localparam t_used  FIFO_LIMIT = t_used'(FIFO_DEPTH);

    typedef enum logic [1:0] {
        KIND_PIXEL,
        KIND_TAIL,
        KIND_ROW
    } t_item_kind;

    // One accepted item as it leaves the sequencer, aligned with row-store read data.
    typedef struct packed {
        logic       valid;
        t_item_kind kind;
        logic       emit;
        logic       boost;
        logic       fend;
        t_col       addr;
        t_rgb       rgb;
    } t_seq_item;

    typedef struct packed {
        t_pix red;
        t_pix green;
        t_pix blue;
        logic frame_end;
    } t_out_pix;

endpackage

`default_nettype wire

// File: design/hbf_stream_if.sv
// Valid/ready stream interfaces for the filter's pixel input and pixel output.
// Depends on hbf_pkg for the field widths.
`default_nettype none

interface hbf_in_if;
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [hbf_pkg::PIX_W-1:0] in_red;
    logic [hbf_pkg::PIX_W-1:0] in_green;
    logic [hbf_pkg::PIX_W-1:0] in_blue;

    modport source (output valid, command, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, command, in_red, in_green, in_blue, output ready);
endinterface

interface hbf_out_if;
    logic                     valid;
    logic                     ready;
    logic [hbf_pkg::PIX_W-1:0] out_red;
    logic [hbf_pkg::PIX_W-1:0] out_green;
    logic [hbf_pkg::PIX_W-1:0] out_blue;
    logic                     frame_end;

    modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

`default_nettype wire

// File: design/highboost_3x3_filter_core.sv
// Top level of the streaming 3x3 high-boost filter on the red channel.
// Depends on hbf_pkg, hbf_stream_if, hbf_ram, hbf_sequencer, hbf_datapath, hbf_out_fifo.
//
//   Channel   Direction  Transfer when         Payload
//   i_pix     in         valid && ready        command, in_red, in_green, in_blue
//   o_pix     out        valid && ready        out_red, out_green, out_blue, frame_end
//   i_cfg_*   in         i_cfg_we high         i_cfg_index, i_cfg_wdata (no read-back)
//
// One input transfer per clock is sustained while i_pix.ready is high; the rate is set by
// the row-store port pair, which takes one read at the accepting edge and one write-back
// in the following cycle. A result passes the item, stage 2 and stage 3 registers, is
// written into the eight-entry output queue and is offered on o_pix from the next cycle
// on. Reset restores the configuration defaults and clears the frame position and queue;
// the row stores are not cleared, since an entry is always written before it is shown.
// i_pix.ready drops only when queued plus in-flight results would fill the queue.
`default_nettype none

module highboost_3x3_filter_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [hbf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [hbf_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    hbf_in_if.sink                              i_pix,
    hbf_out_if.source                           o_pix
);

    // Configuration registers. Writing a geometry register restarts the frame.
    logic [hbf_pkg::CFG_W_W-1:0]    r_image_width;
    logic [hbf_pkg::CFG_H_W-1:0]    r_image_height;
    logic [hbf_pkg::CFG_GAIN_W-1:0] r_center_gain;
    logic                           restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= hbf_pkg::RST_WIDTH;
            r_image_height <= hbf_pkg::RST_HEIGHT;
            r_center_gain  <= hbf_pkg::RST_GAIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hbf_pkg::CFG_IDX_WIDTH: begin
                    r_image_width <= i_cfg_wdata[hbf_pkg::CFG_W_W-1:0];
                end
                hbf_pkg::CFG_IDX_HEIGHT: begin
                    r_image_height <= i_cfg_wdata[hbf_pkg::CFG_H_W-1:0];
                end
                hbf_pkg::CFG_IDX_GAIN: begin
                    r_center_gain <= i_cfg_wdata[hbf_pkg::CFG_GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign restart = i_cfg_we && ((i_cfg_index == hbf_pkg::CFG_IDX_WIDTH) ||
                                  (i_cfg_index == hbf_pkg::CFG_IDX_HEIGHT));

    // Input flow control: every result still in the pipeline holds a queue slot in reserve,
    // so the pipeline itself never stalls and the row-store read data is always consumed.
    hbf_pkg::t_level    fifo_level;
    hbf_pkg::t_inflight inflight;
    hbf_pkg::t_used     used;
    logic               accept;

    assign used        = hbf_pkg::t_used'(fifo_level) + hbf_pkg::t_used'(inflight);
    assign i_pix.ready = (used < hbf_pkg::FIFO_LIMIT);
    assign accept      = i_pix.valid && i_pix.ready;

    // Frame position and row-store read issue.
    logic               rd_en;
    hbf_pkg::t_col      rd_addr;
    hbf_pkg::t_seq_item item;

    hbf_sequencer u_sequencer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_command      (i_pix.command),
        .i_rgb          ({i_pix.in_red, i_pix.in_green, i_pix.in_blue}),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_restart      (restart),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .o_item         (item)
    );

    // The two row stores share their addresses: a pixel at column c reads both entries
    // at c and, in the following cycle, moves the middle entry up and writes itself
    // into the middle. Outside a restart, the same column is not read again for at least
    // three transfers, so the write-back always lands before the next read of that entry.
    logic          wr_en;
    hbf_pkg::t_col wr_addr;
    hbf_pkg::t_rgb up_wdata, mid_wdata;
    hbf_pkg::t_rgb up_rdata, mid_rdata;

    hbf_ram #(
        .WIDTH (hbf_pkg::RGB_W),
        .DEPTH (hbf_pkg::MAX_WIDTH)
    ) u_upper_row (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (up_wdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (up_rdata)
    );

    hbf_ram #(
        .WIDTH (hbf_pkg::RGB_W),
        .DEPTH (hbf_pkg::MAX_WIDTH)
    ) u_middle_row (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (mid_wdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (mid_rdata)
    );

    // Window, filter arithmetic and result assembly.
    logic              push;
    hbf_pkg::t_out_pix push_data;

    hbf_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (item),
        .i_up_rdata    (up_rdata),
        .i_mid_rdata   (mid_rdata),
        .i_center_gain (r_center_gain),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_up_wdata    (up_wdata),
        .o_mid_wdata   (mid_wdata),
        .o_push        (push),
        .o_push_data   (push_data),
        .o_inflight    (inflight)
    );

    hbf_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_level     (fifo_level),
        .o_pix       (o_pix)
    );

endmodule

`default_nettype wire

// File: design/hbf_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependency.
`default_nettype none

module hbf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: design/hbf_sequencer.sv
// Frame position tracking: column and row counters, drain control, row-store reads.
// Depends on hbf_pkg.
`default_nettype none

module hbf_sequencer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic                        i_command,
    input  wire hbf_pkg::t_rgb               i_rgb,
    input  wire logic [hbf_pkg::CFG_W_W-1:0] i_image_width,
    input  wire logic [hbf_pkg::CFG_H_W-1:0] i_image_height,
    input  wire logic                        i_restart,
    output      logic                        o_rd_en,
    output      hbf_pkg::t_col               o_rd_addr,
    output      hbf_pkg::t_seq_item          o_item
);

    hbf_pkg::t_col      r_col, n_col;
    hbf_pkg::t_row      r_row, n_row;
    logic               r_tail_done, n_tail_done;
    hbf_pkg::t_seq_item r_item, n_item;

    hbf_pkg::t_eff_w w_ext;
    hbf_pkg::t_eff_w eff_w;
    hbf_pkg::t_col   w_last;
    hbf_pkg::t_row   eff_h;
    logic            draining;
    logic            col_last;
    logic            col_nz, col_ge2, row_nz, row_ge2;

    // Effective geometry: width held to 3..MAX_WIDTH, height to at least 3.
    always_comb begin
        w_ext = hbf_pkg::t_eff_w'(i_image_width);
        if (w_ext < hbf_pkg::MIN_W_EXT) begin
            eff_w = hbf_pkg::MIN_W_EXT;
        end else if (w_ext > hbf_pkg::MAX_W_EXT) begin
            eff_w = hbf_pkg::MAX_W_EXT;
        end else begin
            eff_w = w_ext;
        end
        w_last = hbf_pkg::t_col'(eff_w - hbf_pkg::ONE_W_EXT);
        eff_h  = (i_image_height < hbf_pkg::MIN_H) ? hbf_pkg::MIN_H : i_image_height;
    end

    assign draining = (r_row >= eff_h);
    assign col_last = (r_col == w_last);
    assign col_nz   = (r_col != '0);
    assign col_ge2  = (r_col[hbf_pkg::COL_W-1:1] != '0);
    assign row_nz   = (r_row != '0);
    assign row_ge2  = (r_row[hbf_pkg::CFG_H_W-1:1] != '0);

    always_comb begin
        n_col        = r_col;
        n_row        = r_row;
        n_tail_done  = r_tail_done;
        o_rd_en      = 1'b0;
        n_item.valid = 1'b0;
        n_item.kind  = hbf_pkg::KIND_PIXEL;
        n_item.emit  = 1'b0;
        n_item.boost = 1'b0;
        n_item.fend  = 1'b0;
        n_item.addr  = r_col;
        n_item.rgb   = i_rgb;

        if (i_accept) begin
            if (draining) begin
                if (!r_tail_done) begin
                    // The last pixel of the second-to-last row comes out first.
                    n_tail_done  = 1'b1;
                    n_item.valid = 1'b1;
                    n_item.kind  = hbf_pkg::KIND_TAIL;
                    n_item.emit  = 1'b1;
                end else begin
                    n_item.valid = 1'b1;
                    n_item.kind  = hbf_pkg::KIND_ROW;
                    n_item.emit  = 1'b1;
                    o_rd_en      = 1'b1;
                    if (col_last) begin
                        n_item.fend = 1'b1;
                        n_col       = '0;
                        n_row       = '0;
                        n_tail_done = 1'b0;
                    end else begin
                        n_col = r_col + hbf_pkg::t_col'(1);
                    end
                end
            end else if (!i_command) begin
                n_item.valid = 1'b1;
                n_item.kind  = hbf_pkg::KIND_PIXEL;
                n_item.emit  = (col_nz && row_nz) || (!col_nz && row_ge2);
                n_item.boost = row_ge2 && col_ge2;
                o_rd_en      = 1'b1;
                if (col_last) begin
                    n_col = '0;
                    n_row = r_row + hbf_pkg::t_row'(1);
                end else begin
                    n_col = r_col + hbf_pkg::t_col'(1);
                end
            end
        end

        if (i_restart) begin
            n_col       = '0;
            n_row       = '0;
            n_tail_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_tail_done <= 1'b0;
            r_item      <= '0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_tail_done <= n_tail_done;
            r_item      <= n_item;
        end
    end

    assign o_rd_addr = r_col;
    assign o_item    = r_item;

endmodule

`default_nettype wire

// File: design/hbf_datapath.sv
// Row-store write-back, red window and the three-stage high-boost arithmetic.
// Depends on hbf_pkg.
`default_nettype none

module hbf_datapath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire hbf_pkg::t_seq_item             i_item,
    input  wire hbf_pkg::t_rgb                  i_up_rdata,
    input  wire hbf_pkg::t_rgb                  i_mid_rdata,
    input  wire logic [hbf_pkg::CFG_GAIN_W-1:0] i_center_gain,
    output      logic                           o_wr_en,
    output      hbf_pkg::t_col                  o_wr_addr,
    output      hbf_pkg::t_rgb                  o_up_wdata,
    output      hbf_pkg::t_rgb                  o_mid_wdata,
    output      logic                           o_push,
    output      hbf_pkg::t_out_pix              o_push_data,
    output      hbf_pkg::t_inflight             o_inflight
);

    // Window columns: c1 is the older kept column, c2 the newer; row 1 of c2 is the center.
    hbf_pkg::t_pix r_win_c1 [hbf_pkg::WIN_ROWS];
    hbf_pkg::t_pix r_win_c2 [hbf_pkg::WIN_ROWS];
    hbf_pkg::t_rgb r_prev_mid;

    logic          s1_pix, s1_emit;
    hbf_pkg::t_pix up_red, mid_red, in_red;

    logic          r_s2_emit, r_s2_boost, r_s2_fend;
    hbf_pkg::t_rgb r_s2_rgb, n_s2_rgb;
    hbf_pkg::t_prod r_s2_prod, n_s2_prod;
    hbf_pkg::t_nsum r_s2_nsum, n_s2_nsum;

    logic          r_s3_emit, r_s3_boost, r_s3_fend;
    hbf_pkg::t_rgb r_s3_rgb;
    hbf_pkg::t_x   r_s3_x, n_s3_x;
    hbf_pkg::t_acc s2_diff;

    hbf_pkg::t_mq  s3_mq;
    hbf_pkg::t_quo s3_quo;
    hbf_pkg::t_pix s3_red;

    // Stage 1: row-store data is here; write back, neighbor sum, center product.
    assign s1_pix  = i_item.valid && (i_item.kind == hbf_pkg::KIND_PIXEL);
    assign s1_emit = i_item.valid && i_item.emit;
    assign up_red  = i_up_rdata[hbf_pkg::RGB_W-1 -: hbf_pkg::PIX_W];
    assign mid_red = i_mid_rdata[hbf_pkg::RGB_W-1 -: hbf_pkg::PIX_W];
    assign in_red  = i_item.rgb[hbf_pkg::RGB_W-1 -: hbf_pkg::PIX_W];

    assign o_wr_en     = s1_pix;
    assign o_wr_addr   = i_item.addr;
    assign o_up_wdata  = i_mid_rdata;
    assign o_mid_wdata = i_item.rgb;

    always_comb begin
        n_s2_nsum = hbf_pkg::t_nsum'(r_win_c1[0]) + hbf_pkg::t_nsum'(r_win_c1[1])
                  + hbf_pkg::t_nsum'(r_win_c1[2]) + hbf_pkg::t_nsum'(r_win_c2[0])
                  + hbf_pkg::t_nsum'(r_win_c2[2]) + hbf_pkg::t_nsum'(up_red)
                  + hbf_pkg::t_nsum'(mid_red) + hbf_pkg::t_nsum'(in_red);
        n_s2_prod = hbf_pkg::t_prod'(i_center_gain) * hbf_pkg::t_prod'(r_win_c2[1]);
        n_s2_rgb  = (i_item.kind == hbf_pkg::KIND_ROW) ? i_mid_rdata : r_prev_mid;
    end

    always_ff @(posedge i_clk) begin
        if (s1_pix) begin
            r_win_c1[0] <= r_win_c2[0];
            r_win_c1[1] <= r_win_c2[1];
            r_win_c1[2] <= r_win_c2[2];
            r_win_c2[0] <= up_red;
            r_win_c2[1] <= mid_red;
            r_win_c2[2] <= in_red;
            r_prev_mid  <= i_mid_rdata;
        end
    end

    // Stage 2: subtract, drop negatives and take the Q.8 integer part.
    always_comb begin
        s2_diff = hbf_pkg::t_acc'(r_s2_prod)
                - hbf_pkg::t_acc'({r_s2_nsum, {hbf_pkg::FRAC_W{1'b0}}});
        if (s2_diff[hbf_pkg::ACC_W-1]) begin
            n_s3_x = '0;
        end else begin
            n_s3_x = s2_diff[hbf_pkg::PROD_W-1:hbf_pkg::FRAC_W];
        end
    end

    // Stage 3: divide by nine through the reciprocal and clamp to the pixel range.
    always_comb begin
        s3_mq  = hbf_pkg::t_mq'(r_s3_x) * hbf_pkg::RECIP_NINE;
        s3_quo = s3_mq[hbf_pkg::MQ_W-1:hbf_pkg::RECIP_SHIFT];
        if (s3_quo[hbf_pkg::QUO_W-1:hbf_pkg::PIX_W] != '0) begin
            s3_red = '1;
        end else begin
            s3_red = s3_quo[hbf_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_emit <= 1'b0;
            r_s3_emit <= 1'b0;
        end else begin
            r_s2_emit <= s1_emit;
            r_s3_emit <= r_s2_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_boost <= i_item.boost;
        r_s2_fend  <= i_item.fend;
        r_s2_rgb   <= n_s2_rgb;
        r_s2_prod  <= n_s2_prod;
        r_s2_nsum  <= n_s2_nsum;
        r_s3_boost <= r_s2_boost;
        r_s3_fend  <= r_s2_fend;
        r_s3_rgb   <= r_s2_rgb;
        r_s3_x     <= n_s3_x;
    end

    assign o_push                = r_s3_emit;
    assign o_push_data.red       = r_s3_boost ? s3_red
                                              : r_s3_rgb[hbf_pkg::RGB_W-1 -: hbf_pkg::PIX_W];
    assign o_push_data.green     = r_s3_rgb[hbf_pkg::PIX_W +: hbf_pkg::PIX_W];
    assign o_push_data.blue      = r_s3_rgb[hbf_pkg::PIX_W-1:0];
    assign o_push_data.frame_end = r_s3_fend;

    assign o_inflight = hbf_pkg::t_inflight'(s1_emit) + hbf_pkg::t_inflight'(r_s2_emit)
                      + hbf_pkg::t_inflight'(r_s3_emit);

endmodule

`default_nettype wire

// File: design/hbf_out_fifo.sv
// Output queue of finished pixels that drives the output stream.
// Depends on hbf_pkg and hbf_out_if.
`default_nettype none

module hbf_out_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire hbf_pkg::t_out_pix i_push_data,
    output      hbf_pkg::t_level   o_level,
    hbf_out_if.source              o_pix
);

    hbf_pkg::t_out_pix r_mem [hbf_pkg::FIFO_DEPTH];
    hbf_pkg::t_fifo_ptr r_wr_ptr, n_wr_ptr;
    hbf_pkg::t_fifo_ptr r_rd_ptr, n_rd_ptr;
    hbf_pkg::t_level    r_level, n_level;
    logic               pop;

    assign pop = o_pix.valid && o_pix.ready;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + hbf_pkg::t_fifo_ptr'(1) : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + hbf_pkg::t_fifo_ptr'(1) : r_rd_ptr;
        n_level  = r_level;
        if (i_push && !pop) begin
            n_level = r_level + hbf_pkg::t_level'(1);
        end else if (pop && !i_push) begin
            n_level = r_level - hbf_pkg::t_level'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_level         = r_level;
    assign o_pix.valid     = (r_level != '0);
    assign o_pix.out_red   = r_mem[r_rd_ptr].red;
    assign o_pix.out_green = r_mem[r_rd_ptr].green;
    assign o_pix.out_blue  = r_mem[r_rd_ptr].blue;
    assign o_pix.frame_end = r_mem[r_rd_ptr].frame_end;

endmodule

`default_nettype wire
